FILE: design/gdda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdda_pkg
// Shared constants, types and the month-start table for the Gregorian day
// arithmetic core.
// ----------------------------------------------------------------------------
package gdda_pkg;

	// Days in the Gregorian periods
	localparam logic [8:0]  DAYS_1Y    = 9'd365;
	localparam logic [10:0] DAYS_4Y    = 11'd1461;
	localparam logic [15:0] DAYS_100Y  = 16'd36524;
	localparam logic [17:0] DAYS_400Y  = 18'd146097;
	localparam logic [21:0] MAX_SERIAL = 22'd3652058;

	// Reciprocal multipliers: floor(x * RECIP >> SHIFT) is exact or one low
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          SHIFT_100   = 19;
	localparam logic [9:0]  RECIP_400Y  = 10'd918;
	localparam int          SHIFT_400Y  = 27;
	localparam logic [10:0] RECIP_4Y    = 11'd1435;
	localparam int          SHIFT_4Y    = 21;

	// Side information that travels with an item through the date split
	typedef struct packed {
		logic        zero_date;
		logic        range_error;
		logic [22:0] diff;
	} gdda_tag_t;

	// Days before month idx (0 = January) in a common or leap year
	function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
		logic [8:0] base;
		base = 9'd0;
		case (idx)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			default: base = 9'd334;
		endcase
		if (leap && idx >= 4'd2) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

FILE: design/gdda_date_to_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdda_date_to_serial
// Two-stage conversion of a year, month and day to a signed serial day
// number, day 0 being 0001-01-01.
// ----------------------------------------------------------------------------
module gdda_date_to_serial (
	input  logic               clk,
	input  logic               en,
	input  logic [13:0]        year,
	input  logic [3:0]         month,
	input  logic [4:0]         day,
	output logic signed [22:0] serial
);
	import gdda_pkg::*;

	logic [13:0] y_c;
	logic [3:0]  m_c;
	logic [26:0] prod_c;

	logic [13:0] y_s1;
	logic [3:0]  m_s1;
	logic [4:0]  d_s1;
	logic [6:0]  q_s1;

	logic [13:0] r100;
	logic        century;
	logic [6:0]  pq;
	logic [13:0] p;
	logic        leap;
	logic [22:0] sum;

	logic [22:0] serial_s2;

	// Stage 1: saturate the year and month, take year / 100 by reciprocal
	always_comb begin
		y_c = year;
		if (year == 14'd0) begin
			y_c = 14'd1;
		end else if (year > 14'd9999) begin
			y_c = 14'd9999;
		end
		m_c = month;
		if (month == 4'd0) begin
			m_c = 4'd1;
		end else if (month > 4'd12) begin
			m_c = 4'd12;
		end
		prod_c = {13'd0, y_c} * {14'd0, RECIP_100};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1 <= y_c;
			m_s1 <= m_c;
			d_s1 <= day;
			q_s1 <= 7'(prod_c >> SHIFT_100);
		end
	end

	// Stage 2: leap rule and the day count
	always_comb begin
		r100    = y_s1 - 14'({7'd0, q_s1} * 14'd100);
		century = (r100 == 14'd0);
		// (y-1)/100 drops by one on a century year
		pq      = q_s1 - {6'd0, century};
		p       = y_s1 - 14'd1;
		leap    = century ? (q_s1[1:0] == 2'd0) : (y_s1[1:0] == 2'd0);
		sum     = {9'd0, p} * 23'd365
		        + {11'd0, p[13:2]}
		        - {16'd0, pq}
		        + {18'd0, pq[6:2]}
		        + {14'd0, month_start(leap, m_s1 - 4'd1)}
		        + {18'd0, d_s1}
		        - 23'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			serial_s2 <= sum;
		end
	end

	assign serial = $signed(serial_s2);

endmodule

FILE: design/gdda_serial_to_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdda_serial_to_date
// Seven-stage split of a serial day number into 400-, 100-, 4- and 1-year
// periods and a month search, with valid bits and side tags in step.
// ----------------------------------------------------------------------------
module gdda_serial_to_date (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  gdda_pkg::gdda_tag_t in_tag,
	input  logic [21:0]         serial,
	output logic                out_valid,
	output gdda_pkg::gdda_tag_t out_tag,
	output logic [13:0]         year,
	output logic [3:0]          month,
	output logic [4:0]          day
);
	import gdda_pkg::*;

	logic      v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	gdda_tag_t tag_s4, tag_s5, tag_s6, tag_s7, tag_s8, tag_s9, tag_s10;

	logic [31:0] prod_a;
	logic [21:0] n_s4;
	logic [4:0]  qa_s4;

	logic [21:0] r_b;
	logic [4:0]  q400_s5;
	logic [17:0] r400_s5;

	logic [1:0]  q100_c;
	logic [4:0]  q400_s6;
	logic [1:0]  q100_s6;
	logic [15:0] r100_s6;

	logic [26:0] prod_d;
	logic [4:0]  q400_s7;
	logic [1:0]  q100_s7;
	logic [15:0] r100_s7;
	logic [4:0]  qa4_s7;

	logic [15:0] r_e;
	logic [4:0]  q400_s8;
	logic [1:0]  q100_s8;
	logic [4:0]  q4_s8;
	logic [10:0] r4_s8;

	logic [1:0]  q1_c;
	logic [13:0] y_f;
	logic [13:0] y_s9;
	logic [8:0]  doy_s9;
	logic        leap_s9;

	logic [3:0]  mon_g;
	logic [8:0]  dom_g;
	logic [13:0] y_s10;
	logic [3:0]  m_s10;
	logic [4:0]  d_s10;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s4  <= in_valid;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// Stage 4: estimate the 400-year count
	assign prod_a = {10'd0, serial} * {22'd0, RECIP_400Y};

	// Stage 5: remainder, fix an estimate that came out one low
	assign r_b = n_s4 - 22'({17'd0, qa_s4} * {4'd0, DAYS_400Y});

	// Stage 6: 100-year count, capped at three
	always_comb begin
		if (r400_s5 >= 18'({DAYS_100Y, 1'b0} + {2'd0, DAYS_100Y})) begin
			q100_c = 2'd3;
		end else if (r400_s5 >= {1'b0, DAYS_100Y, 1'b0}) begin
			q100_c = 2'd2;
		end else if (r400_s5 >= {2'd0, DAYS_100Y}) begin
			q100_c = 2'd1;
		end else begin
			q100_c = 2'd0;
		end
	end

	// Stage 7: estimate the 4-year count
	assign prod_d = {11'd0, r100_s6} * {16'd0, RECIP_4Y};

	// Stage 8: remainder within the 4-year block
	assign r_e = r100_s7 - 16'({11'd0, qa4_s7} * {5'd0, DAYS_4Y});

	// Stage 9: single years, capped at three, and the year number
	always_comb begin
		if (r4_s8 >= 11'({DAYS_1Y, 1'b0} + {2'd0, DAYS_1Y})) begin
			q1_c = 2'd3;
		end else if (r4_s8 >= {1'b0, DAYS_1Y, 1'b0}) begin
			q1_c = 2'd2;
		end else if (r4_s8 >= {2'd0, DAYS_1Y}) begin
			q1_c = 2'd1;
		end else begin
			q1_c = 2'd0;
		end
		y_f = {9'd0, q400_s8} * 14'd400 + {12'd0, q100_s8} * 14'd100
		    + {7'd0, q4_s8, 2'b00} + {12'd0, q1_c} + 14'd1;
	end

	// Stage 10: month search over the month-start table
	always_comb begin
		mon_g = 4'd1;
		for (int i = 1; i < 12; i++) begin
			if (month_start(leap_s9, 4'(i)) <= doy_s9) begin
				mon_g = 4'(i + 1);
			end
		end
		dom_g = doy_s9 - month_start(leap_s9, mon_g - 4'd1) + 9'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s4  <= in_tag;
			n_s4    <= serial;
			qa_s4   <= 5'(prod_a >> SHIFT_400Y);

			tag_s5  <= tag_s4;
			if (r_b >= {4'd0, DAYS_400Y}) begin
				q400_s5 <= qa_s4 + 5'd1;
				r400_s5 <= 18'(r_b - {4'd0, DAYS_400Y});
			end else begin
				q400_s5 <= qa_s4;
				r400_s5 <= r_b[17:0];
			end

			tag_s6  <= tag_s5;
			q400_s6 <= q400_s5;
			q100_s6 <= q100_c;
			r100_s6 <= 16'(r400_s5 - 18'({16'd0, q100_c} * {2'd0, DAYS_100Y}));

			tag_s7  <= tag_s6;
			q400_s7 <= q400_s6;
			q100_s7 <= q100_s6;
			r100_s7 <= r100_s6;
			qa4_s7  <= 5'(prod_d >> SHIFT_4Y);

			tag_s8  <= tag_s7;
			q400_s8 <= q400_s7;
			q100_s8 <= q100_s7;
			if (r_e >= {5'd0, DAYS_4Y}) begin
				q4_s8 <= qa4_s7 + 5'd1;
				r4_s8 <= 11'(r_e - {5'd0, DAYS_4Y});
			end else begin
				q4_s8 <= qa4_s7;
				r4_s8 <= r_e[10:0];
			end

			tag_s9  <= tag_s8;
			y_s9    <= y_f;
			doy_s9  <= 9'(r4_s8 - 11'({9'd0, q1_c} * {2'd0, DAYS_1Y}));
			// Last year of a 4-year block is leap unless it closes a plain century
			leap_s9 <= (q1_c == 2'd3) && !((q4_s8 == 5'd24) && (q100_s8 != 2'd3));

			tag_s10 <= tag_s9;
			if (tag_s9.zero_date) begin
				y_s10 <= 14'd0;
				m_s10 <= 4'd0;
				d_s10 <= 5'd0;
			end else begin
				y_s10 <= y_s9;
				m_s10 <= mon_g;
				d_s10 <= dom_g[4:0];
			end
		end
	end

	assign out_valid = v_s10;
	assign out_tag   = tag_s10;
	assign year      = y_s10;
	assign month     = m_s10;
	assign day       = d_s10;

`ifndef SYNTH
	a_r400_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (r400_s5 < DAYS_400Y))
		else $error("400-year remainder out of range");
	a_r4_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> (r4_s8 < DAYS_4Y))
		else $error("4-year remainder out of range");
	a_doy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 |-> (doy_s9 <= (leap_s9 ? DAYS_1Y : DAYS_1Y - 9'd1)))
		else $error("day of year past the end of the year");
`endif

endmodule

FILE: design/gregorian_date_day_arithmetic_core.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle; the pipeline advances whenever the output
// register is empty or being taken, so stalls hold every stage in place.
// Reset clears the valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
// gregorian_date_day_arithmetic_core
// Proleptic Gregorian date shift by a day offset and day difference of two
// dates, as a ten-stage pipeline with stream handshakes.
// ----------------------------------------------------------------------------
module gregorian_date_day_arithmetic_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// year[13:0], month[17:14], day[22:18], day_offset[45:23],
	// other_year[59:46], other_month[63:60], other_day[68:64], zero pad [71:69]
	input  logic [71:0] s_tdata,
	// action[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_year[13:0], result_month[17:14], result_day[22:18],
	// day_difference[45:23], zero pad [47:46]
	output logic [47:0] m_tdata,
	// range_error[0]
	output logic        m_tuser
);
	import gdda_pkg::*;

	logic en;

	logic        v_s1, v_s2, v_s3;
	logic        act_s1, act_s2;
	logic [22:0] off_s1, off_s2;

	logic signed [22:0] ser_a, ser_b;

	logic signed [23:0] shifted;
	logic               err_c;
	gdda_tag_t          tag_c;
	logic [21:0]        n_c;

	gdda_tag_t   tag_s3;
	logic [21:0] n_s3;

	gdda_tag_t   tag_out;
	logic [13:0] y_out;
	logic [3:0]  m_out;
	logic [4:0]  d_out;

	// Advance when the output register is free or being drained
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= s_tuser;
			off_s1 <= s_tdata[45:23];
			act_s2 <= act_s1;
			off_s2 <= off_s1;
			tag_s3 <= tag_c;
			n_s3   <= n_c;
		end
	end

	gdda_date_to_serial u_first (
		.clk    (clk),
		.en     (en),
		.year   (s_tdata[13:0]),
		.month  (s_tdata[17:14]),
		.day    (s_tdata[22:18]),
		.serial (ser_a)
	);

	gdda_date_to_serial u_second (
		.clk    (clk),
		.en     (en),
		.year   (s_tdata[59:46]),
		.month  (s_tdata[63:60]),
		.day    (s_tdata[68:64]),
		.serial (ser_b)
	);

	// Stage 3: apply the offset or take the difference
	always_comb begin
		shifted = {ser_a[22], ser_a} + {off_s2[22], off_s2};
		err_c   = (shifted < 24'sd0) || (shifted > $signed({2'b00, MAX_SERIAL}));
		tag_c.zero_date   = act_s2 || err_c;
		tag_c.range_error = !act_s2 && err_c;
		tag_c.diff        = act_s2 ? 23'(ser_a - ser_b) : 23'd0;
		n_c = (act_s2 || err_c) ? 22'd0 : shifted[21:0];
	end

	gdda_serial_to_date u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_tag    (tag_s3),
		.serial    (n_s3),
		.out_valid (m_tvalid),
		.out_tag   (tag_out),
		.year      (y_out),
		.month     (m_out),
		.day       (d_out)
	);

	assign m_tdata = {2'b00, tag_out.diff, d_out, m_out, y_out};
	assign m_tuser = tag_out.range_error;

`ifndef SYNTH
	a_err_zero_date: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[22:0] == 23'd0))
		else $error("range error with a nonzero date");
	a_err_zero_diff: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[45:23] == 23'd0))
		else $error("range error with a nonzero day difference");
	a_date_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[17:14] != 4'd0)) |->
		((m_tdata[17:14] <= 4'd12) && (m_tdata[22:18] != 5'd0)
		&& (m_tdata[13:0] != 14'd0) && (m_tdata[45:23] == 23'd0)))
		else $error("shifted date fields inconsistent");
`endif

endmodule
